>>> src/shwq_pkg.sv
`timescale 1ns / 1ps

package shwq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_WINDOW = 2'd1,
    OP_MINMAX = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    op_t                operation;
    logic signed [63:0] sample_time;
    logic signed [31:0] sample_value;
    logic signed [63:0] window_from;
    logic signed [63:0] window_to;
  } cmd_t;

  typedef struct packed {
    logic                 point_valid;
    logic signed [63:0]   point_time;
    logic signed [31:0]   point_value;
    logic signed [31:0]   smallest_value;
    logic signed [31:0]   largest_value;
    logic [COUNT_W-1:0]   held_count;
    logic                 last;
  } res_t;

endpackage

>>> src/sample_history_window_query.sv
`timescale 1ns / 1ps

// Circular history of DEPTH timestamped samples with window and min/max readout.
// Command channel (cmd_valid / cmd_stall / cmd) takes one beat per operation;
// result channel (res_valid / res_stall / res) returns the beats it causes, the
// final one flagged by last. Every operation gives at least one result beat.
// Push and clear: one beat, loaded into the output register in the cycle after
// the command beat; a new command is taken the next cycle unless that beat is held back.
// Window and min/max queries walk the held entries oldest to newest through the
// registered read port of the sample memory: a read state (address) then a
// check state (compare) per held entry, and a finish state for the closing beat.
// An empty history, or a reversed window in a window query, answers from idle.
// cmd_stall is high for the whole walk. A held-back result keeps the walk
// waiting at the next match or at the closing beat; nothing is dropped.
// Reset (rst, synchronous) empties the history and drops any result in flight;
// the sample memory itself is not cleared and needs no clearing pass.
module sample_history_window_query #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  shwq_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output shwq_pkg::res_t res
);
  import shwq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic signed [63:0] time_mem  [DEPTH];
  logic signed [31:0] value_mem [DEPTH];

  logic [AW-1:0]      write_pointer;
  logic [CW-1:0]      fill_count;
  logic [AW-1:0]      ptr;
  logic [CW-1:0]      remaining;
  op_t                op;
  logic signed [63:0] win_from;
  logic signed [63:0] win_to;
  logic signed [63:0] rd_time;
  logic signed [31:0] rd_value;
  logic               pend_valid;
  logic signed [63:0] pend_time;
  logic signed [31:0] pend_value;
  logic               first;
  logic signed [31:0] low_mark;
  logic signed [31:0] high_mark;

  logic          out_free;
  logic          accept;
  logic          full;
  logic          match;
  logic [AW-1:0] ptr_next;
  logic [AW-1:0] wp_next;

  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = rst || (state != ST_IDLE) || !out_free;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (fill_count == CW'(DEPTH));
  assign match     = (win_from <= rd_time) && (rd_time <= win_to);
  assign ptr_next  = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign wp_next   = (write_pointer == AW'(DEPTH - 1)) ? '0 : write_pointer + 1'b1;

  always_ff @(posedge clk) begin
    if (accept && cmd.operation == OP_PUSH) begin
      time_mem[write_pointer]  <= cmd.sample_time;
      value_mem[write_pointer] <= cmd.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_time  <= time_mem[ptr];
    rd_value <= value_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_pointer <= '0;
      fill_count    <= '0;
      res_valid     <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op         <= cmd.operation;
            win_from   <= cmd.window_from;
            win_to     <= cmd.window_to;
            ptr        <= full ? write_pointer : '0;
            remaining  <= fill_count;
            pend_valid <= 1'b0;
            first      <= 1'b1;
            res        <= '0;
            res.last   <= 1'b1;
            res.held_count <= COUNT_W'(fill_count);
            unique case (cmd.operation)
              OP_PUSH: begin
                write_pointer <= wp_next;
                if (!full) begin
                  fill_count     <= fill_count + 1'b1;
                  res.held_count <= COUNT_W'(fill_count + 1'b1);
                end
                res_valid <= 1'b1;
              end
              OP_CLEAR: begin
                write_pointer  <= '0;
                fill_count     <= '0;
                res.held_count <= '0;
                res_valid      <= 1'b1;
              end
              OP_WINDOW: begin
                if (fill_count == '0 || cmd.window_from > cmd.window_to) begin
                  res_valid <= 1'b1;
                end else begin
                  state <= ST_READ;
                end
              end
              OP_MINMAX: begin
                if (fill_count == '0) begin
                  res_valid <= 1'b1;
                end else begin
                  state <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          // hold on a second match until the earlier one can leave
          if (!(op == OP_WINDOW && match && pend_valid && !out_free)) begin
            if (op == OP_WINDOW) begin
              if (match) begin
                if (pend_valid) begin
                  res             <= '0;
                  res.point_valid <= 1'b1;
                  res.point_time  <= pend_time;
                  res.point_value <= pend_value;
                  res.held_count  <= COUNT_W'(fill_count);
                  res_valid       <= 1'b1;
                end
                pend_valid <= 1'b1;
                pend_time  <= rd_time;
                pend_value <= rd_value;
              end
            end else begin
              first <= 1'b0;
              if (first || rd_value < low_mark) begin
                low_mark <= rd_value;
              end
              if (first || rd_value > high_mark) begin
                high_mark <= rd_value;
              end
            end
            remaining <= remaining - 1'b1;
            ptr       <= ptr_next;
            state     <= (remaining == CW'(1)) ? ST_FINISH : ST_READ;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            res            <= '0;
            res.held_count <= COUNT_W'(fill_count);
            res.last       <= 1'b1;
            if (op == OP_WINDOW) begin
              res.point_valid <= pend_valid;
              res.point_time  <= pend_valid ? pend_time : '0;
              res.point_value <= pend_valid ? pend_value : '0;
            end else begin
              res.smallest_value <= low_mark;
              res.largest_value  <= high_mark;
            end
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/shwq_checker.sv
`timescale 1ns / 1ps

module shwq_checker #(
  parameter int DEPTH = 64
) (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input shwq_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_stall,
  input shwq_pkg::res_t res
);
  import shwq_pkg::*;

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result beat changed");

  // push and clear answer in the next cycle with a closing beat
  a_quick_op: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.operation == OP_PUSH || cmd.operation == OP_CLEAR)
    |=> res_valid && res.last && !res.point_valid)
    else $error("push or clear gave no closing beat");

  // clear empties the history
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd.operation == OP_CLEAR |=> res.held_count == '0)
    else $error("clear left samples held");

  // a beat without a point closes its command
  a_nopoint_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.point_valid |-> res.last)
    else $error("empty result beat not flagged last");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.held_count <= COUNT_W'(DEPTH))
    else $error("held count beyond depth");

endmodule

bind sample_history_window_query shwq_checker #(.DEPTH(DEPTH)) u_shwq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
